@@ design/twpws_pkg.sv @@
// Shared types and constants for the two-wire parity word slave.
package twpws_pkg;

  localparam int DATA_BITS_DEF = 10;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_START_SDA    = 4'd1,
    PH_START_SCL    = 4'd2,
    PH_DIR_HIGH     = 4'd3,
    PH_DIR_LOW      = 4'd4,
    PH_RX_HIGH      = 4'd5,
    PH_RX_LOW       = 4'd6,
    PH_TX_LOW       = 4'd7,
    PH_TX_HIGH      = 4'd8,
    PH_TX_LAST      = 4'd9,
    PH_END_SDA_LOW  = 4'd10,
    PH_END_SCL_HIGH = 4'd11,
    PH_END_SDA_HIGH = 4'd12
  } phase_t;

endpackage

@@ design/twpws_core.sv @@
// Line-sample state machine that advances one step per accepted word and forms its result.
module twpws_core import twpws_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF,
  parameter int RES_W     = DATA_BITS + 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic                 scl,
  input  logic                 sda,
  input  logic [DATA_BITS-1:0] txw,
  output logic [RES_W-1:0]     result
);

  localparam int FRAME_BITS = DATA_BITS + 1;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int IDX_W      = $clog2(FRAME_BITS);
  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BITS);

  phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]      bit_count_r, bit_count_nxt;
  logic [FRAME_BITS-1:0] rx_shift_r, rx_shift_nxt;
  logic [FRAME_BITS-1:0] tx_shift_r, tx_shift_nxt;
  logic                  direction_r, direction_nxt;
  logic                  drive_level_r, drive_level_nxt;

  logic [CNT_W-1:0]      cnt_dec;
  logic                  valid, ending, releasing, enabled, pok;
  logic [DATA_BITS-1:0]  word;

  assign cnt_dec = bit_count_r - 1'b1;

  always_comb begin
    phase_nxt       = phase_r;
    bit_count_nxt   = bit_count_r;
    rx_shift_nxt    = rx_shift_r;
    tx_shift_nxt    = tx_shift_r;
    direction_nxt   = direction_r;
    drive_level_nxt = drive_level_r;
    valid           = 1'b0;
    ending          = 1'b0;
    releasing       = 1'b0;
    word            = '0;
    pok             = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (scl && sda) phase_nxt = PH_START_SDA;
      end
      PH_START_SDA: begin
        if (!sda) phase_nxt = PH_START_SCL;
      end
      PH_START_SCL: begin
        if (!scl) phase_nxt = PH_DIR_HIGH;
      end
      PH_DIR_HIGH: begin
        if (scl) begin
          direction_nxt = sda;
          if (sda) tx_shift_nxt = {^txw, txw};
          phase_nxt = PH_DIR_LOW;
        end
      end
      PH_DIR_LOW: begin
        if (!scl) begin
          if (direction_r) begin
            bit_count_nxt   = FRAME_CNT;
            drive_level_nxt = tx_shift_r[FRAME_BITS-1];
            phase_nxt       = PH_TX_HIGH;
          end else begin
            bit_count_nxt = '0;
            rx_shift_nxt  = '0;
            phase_nxt     = PH_RX_HIGH;
          end
        end
      end
      PH_RX_HIGH: begin
        if (scl) begin
          rx_shift_nxt  = {rx_shift_r[FRAME_BITS-2:0], sda};
          bit_count_nxt = bit_count_r + 1'b1;
          if (bit_count_nxt >= FRAME_CNT) begin
            valid = 1'b1;
            word  = rx_shift_nxt[DATA_BITS-1:0];
            pok   = (rx_shift_nxt[DATA_BITS] == ^rx_shift_nxt[DATA_BITS-1:0]);
          end
          phase_nxt = PH_RX_LOW;
        end
      end
      PH_RX_LOW: begin
        if (!scl) phase_nxt = (bit_count_r >= FRAME_CNT) ? PH_END_SDA_LOW : PH_RX_HIGH;
      end
      PH_TX_LOW: begin
        if (!scl) begin
          drive_level_nxt = tx_shift_r[cnt_dec[IDX_W-1:0]];
          phase_nxt       = PH_TX_HIGH;
        end
      end
      PH_TX_HIGH: begin
        if (scl) begin
          if (bit_count_r != '0) bit_count_nxt = cnt_dec;
          phase_nxt = (bit_count_nxt == '0) ? PH_TX_LAST : PH_TX_LOW;
        end
      end
      PH_TX_LAST: begin
        if (!scl) begin
          drive_level_nxt = 1'b0;
          releasing       = 1'b1;
          phase_nxt       = PH_END_SDA_LOW;
        end
      end
      PH_END_SDA_LOW: begin
        if (!sda) phase_nxt = PH_END_SCL_HIGH;
      end
      PH_END_SCL_HIGH: begin
        if (scl) phase_nxt = PH_END_SDA_HIGH;
      end
      PH_END_SDA_HIGH: begin
        if (sda) begin
          ending    = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign enabled = releasing || (phase_nxt == PH_TX_LOW) || (phase_nxt == PH_TX_HIGH) ||
                   (phase_nxt == PH_TX_LAST);

  assign result = {ending, direction_nxt, pok, word, valid, enabled,
                   enabled & drive_level_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_count_r   <= '0;
      rx_shift_r    <= '0;
      tx_shift_r    <= '0;
      direction_r   <= 1'b0;
      drive_level_r <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      bit_count_r   <= bit_count_nxt;
      rx_shift_r    <= rx_shift_nxt;
      tx_shift_r    <= tx_shift_nxt;
      direction_r   <= direction_nxt;
      drive_level_r <= drive_level_nxt;
    end
  end

endmodule

@@ design/twpws_oreg.sv @@
// Output register that holds one result word until the receiver takes it.
module twpws_oreg #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [WIDTH-1:0] load_data,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             valid_r;
  logic [WIDTH-1:0] data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

@@ design/two_wire_parity_word_slave.sv @@
// Top level of the two-wire parity word slave: stream ports, state machine and output register.
//
// Each input word carries one sample of the clock and data lines plus the word to
// send when the master reads. Every accepted input word yields exactly one result
// word: the data line drive and enable, the received word with its valid flag and
// parity check, the current direction and the stop flag.
//
// The state machine steps once per accepted input word and its result is loaded
// into the output register on the same edge, so a result appears in the cycle after
// its input word is accepted. One input word is taken every cycle while the output
// register can load; the state update feeds the output register directly.
//
// in_tready is high whenever the output register is empty or is being emptied in
// the same cycle, so a stalled receiver holds the pending result and pauses input
// without losing or repeating any word.
//
// Synchronous active-low reset returns the machine to idle with all shift
// registers, the bit count and the direction cleared, and empties the output.
module two_wire_parity_word_slave import twpws_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // Fields from bit 0: scl_level, sda_level, tx_word.
  input  logic [((DATA_BITS+2+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // Fields from bit 0: sda_drive, sda_enable, word_valid, rx_word, parity_ok,
  // master_reads, frame_end.
  output logic [((DATA_BITS+6+7)/8)*8-1:0] out_tdata
);

  localparam int RES_W = DATA_BITS + 6;
  localparam int OUT_W = ((DATA_BITS + 6 + 7) / 8) * 8;

  logic             accept;
  logic [RES_W-1:0] result;

  assign accept = in_tvalid && in_tready;

  twpws_core #(
    .DATA_BITS(DATA_BITS),
    .RES_W    (RES_W)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(accept),
    .scl    (in_tdata[0]),
    .sda    (in_tdata[1]),
    .txw    (in_tdata[DATA_BITS+1:2]),
    .result (result)
  );

  twpws_oreg #(
    .WIDTH(OUT_W)
  ) u_oreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .load_data(OUT_W'(result)),
    .can_load (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the two-wire parity word slave, with a line-level predictor.
module testbench;
  import twpws_pkg::*;

  localparam int ITEMS = 1950;
  localparam int LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic       frame_end;
    logic       master_reads;
    logic       parity_ok;
    logic [9:0] rx_word;
    logic       word_valid;
    logic       sda_enable;
    logic       sda_drive;
  } line_result_t;

  typedef bit [1:0] level_q_t[$];

  class slave_line_tracker;
    phase_t         phase;
    bit [3:0]       bit_count;
    bit [10:0]      rx_shift;
    bit [10:0]      tx_shift;
    bit             direction;
    bit             drive_level;
    line_result_t   expected_lines[$];
    int             failures;

    function new();
      phase = PH_IDLE;
      bit_count = 0;
      rx_shift = 0;
      tx_shift = 0;
      direction = 0;
      drive_level = 0;
      failures = 0;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    function void note_sample(bit scl, bit sda, bit [9:0] txw);
      line_result_t r;
      bit valid;
      bit ending;
      bit releasing;
      bit enabled;
      bit [9:0] word;
      bit pok;
      valid = 0;
      ending = 0;
      releasing = 0;
      word = 0;
      pok = 0;
      case (phase)
        PH_IDLE: if (scl && sda) phase = PH_START_SDA;
        PH_START_SDA: if (!sda) phase = PH_START_SCL;
        PH_START_SCL: if (!scl) phase = PH_DIR_HIGH;
        PH_DIR_HIGH: begin
          if (scl) begin
            direction = sda;
            if (sda) tx_shift = {^txw, txw};
            phase = PH_DIR_LOW;
          end
        end
        PH_DIR_LOW: begin
          if (!scl) begin
            if (direction) begin
              bit_count = 4'd11;
              drive_level = tx_shift[10];
              phase = PH_TX_HIGH;
            end else begin
              bit_count = 0;
              rx_shift = 0;
              phase = PH_RX_HIGH;
            end
          end
        end
        PH_RX_HIGH: begin
          if (scl) begin
            rx_shift = {rx_shift[9:0], sda};
            bit_count = bit_count + 4'd1;
            if (bit_count >= 4'd11) begin
              valid = 1;
              word = rx_shift[9:0];
              pok = (rx_shift[10] == ^word);
            end
            phase = PH_RX_LOW;
          end
        end
        PH_RX_LOW: if (!scl) phase = (bit_count >= 4'd11) ? PH_END_SDA_LOW : PH_RX_HIGH;
        PH_TX_LOW: begin
          if (!scl) begin
            drive_level = tx_shift[bit_count - 4'd1];
            phase = PH_TX_HIGH;
          end
        end
        PH_TX_HIGH: begin
          if (scl) begin
            if (bit_count > 0) bit_count = bit_count - 4'd1;
            phase = (bit_count == 0) ? PH_TX_LAST : PH_TX_LOW;
          end
        end
        PH_TX_LAST: begin
          if (!scl) begin
            drive_level = 0;
            releasing = 1;
            phase = PH_END_SDA_LOW;
          end
        end
        PH_END_SDA_LOW: if (!sda) phase = PH_END_SCL_HIGH;
        PH_END_SCL_HIGH: if (scl) phase = PH_END_SDA_HIGH;
        PH_END_SDA_HIGH: begin
          if (sda) begin
            ending = 1;
            phase = PH_IDLE;
          end
        end
        default: phase = PH_IDLE;
      endcase
      enabled = releasing || (phase inside {PH_TX_LOW, PH_TX_HIGH, PH_TX_LAST});
      r.sda_drive = enabled & drive_level;
      r.sda_enable = enabled;
      r.word_valid = valid;
      r.rx_word = word;
      r.parity_ok = pok;
      r.master_reads = direction;
      r.frame_end = ending;
      expected_lines.push_back(r);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(line_result_t got);
      line_result_t e;
      if (expected_lines.size() == 0) begin
        report($sformatf("result %h arrived with nothing expected", got));
        return;
      end
      e = expected_lines.pop_front();
      if (got.sda_drive !== e.sda_drive || got.sda_enable !== e.sda_enable ||
          got.word_valid !== e.word_valid || got.rx_word !== e.rx_word ||
          got.parity_ok !== e.parity_ok || got.master_reads !== e.master_reads ||
          got.frame_end !== e.frame_end) begin
        report($sformatf({"drive %b/%b enable %b/%b valid %b/%b word %h/%h ",
                          "parity_ok %b/%b reads %b/%b end %b/%b (expected/actual)"},
                         e.sda_drive, got.sda_drive, e.sda_enable, got.sda_enable,
                         e.word_valid, got.word_valid, e.rx_word, got.rx_word,
                         e.parity_ok, got.parity_ok, e.master_reads, got.master_reads,
                         e.frame_end, got.frame_end));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  logic        calm = 1'b0;
  logic        hold_req = 1'b0;
  int          accepted = 0;
  int          cycles = 0;
  slave_line_tracker tracker;

  two_wire_parity_word_slave dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Each line level is held for one to three samples, as an oversampled pin would be.
  task automatic put_sample(bit [1:0] lv, bit [9:0] txw);
    int reps;
    reps = ($urandom_range(99) < 60) ? 1 : $urandom_range(3, 2);
    repeat (reps) begin
      while (!calm && $urandom_range(99) < 26) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= {4'b0, txw, lv[1], lv[0]};
      do @(posedge clk); while (!in_tready);
      tracker.note_sample(lv[0], lv[1], txw);
      accepted++;
    end
  endtask

  task automatic play_levels(level_q_t q, int first, int last, bit [9:0] txw);
    for (int i = first; i <= last; i++) put_sample(q[i], txw);
  endtask

  task automatic send_stop();
    put_sample(2'b00, 10'($urandom));
    put_sample(2'b01, 10'($urandom));
    put_sample(2'b11, 10'($urandom));
  endtask

  // Levels are {sda, scl}; the master changes data only while the clock is low, except for start and stop.
  function automatic level_q_t build_frame(bit dir, bit [10:0] bits);
    level_q_t q;
    q.push_back(2'b11);
    q.push_back(2'b01);
    q.push_back(2'b00);
    q.push_back({dir, 1'b0});
    q.push_back({dir, 1'b1});
    q.push_back({dir, 1'b0});
    for (int i = 10; i >= 0; i--) begin
      q.push_back({bits[i], 1'b0});
      q.push_back({bits[i], 1'b1});
      q.push_back({bits[i], 1'b0});
    end
    q.push_back(2'b00);
    q.push_back(2'b01);
    q.push_back(2'b11);
    return q;
  endfunction

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    level_q_t frame;
    bit [9:0] data;
    bit       dir;
    bit       par;
    bit       paused;
    int       pick;
    tracker = new();
    paused = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start with clock falling before data: the fall of data still counts as a start.
    frame = build_frame(1'b0, 11'h7FF);
    put_sample(2'b11, 10'h000);
    put_sample(2'b10, 10'h000);
    play_levels(frame, 2, frame.size() - 1, 10'h000);
    frame = build_frame(1'b1, 11'h000);
    play_levels(frame, 0, frame.size() - 1, 10'h3FF);

    while (accepted < ITEMS) begin
      if (!hold_req && accepted > 600) hold_req <= 1'b1;
      if (accepted > 1000 && accepted < 1300) calm <= 1'b1;
      else calm <= 1'b0;
      if (!paused && accepted > 1400) begin
        paused = 1;
        in_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      dir = 1'($urandom_range(1));
      data = 10'($urandom);
      par = (^data) ^ ($urandom_range(99) < 30);
      frame = build_frame(dir, {par, data});
      if (pick < 80) begin
        play_levels(frame, 0, frame.size() - 1, 10'($urandom));
      end else if (pick < 90) begin
        play_levels(frame, 0, $urandom_range(frame.size() - 2), 10'($urandom));
        send_stop();
      end else begin
        repeat ($urandom_range(12, 1)) put_sample(2'($urandom_range(3)), 10'($urandom));
        send_stop();
      end
    end
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
